### hdl/matrix_multiply_4x4_defines.svh
// Assertion helpers shared by the checker; clk and rst come from the calling scope.
`ifndef MATRIX_MULTIPLY_4X4_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_DEFINES_SVH

// same-cycle implication
`define MM4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mm4_pkg.sv
`default_nettype none

package mm4_pkg;

  localparam int DATA_W            = 32;
  localparam int ROW_W             = 2;
  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;

  typedef struct packed {
    logic wr_en;     // store the input element
    logic wr_right;  // 0: left matrix, 1: right matrix
    logic rd_en;     // read one operand pair
    logic first;     // first term of a dot product
    logic last_k;    // last term of a dot product
    logic load_out;  // move finished sum into the output register
    logic out_last;  // final result of the run
  } mm4_cmd_t;

  typedef struct packed {
    logic acc_done;  // accumulator holds a complete dot product
    logic out_free;  // output register can take a new result this cycle
  } mm4_status_t;

endpackage

`default_nettype wire

### hdl/matrix_multiply_4x4.sv
// channel   direction  handshake            fields
// in        input      in_valid / in_stall  element (32 s)
// out       output     out_valid / out_stall row (2), column (2), product (32 s), last (1)
//
// Load: one element per cycle, 2*DIM*DIM transfers (32 at DIM=4), A then B row-major.
// Compute: each product element comes from the single multiply-accumulate unit, which
//   does DIM reads from the two stores, a multiply and an accumulate per read, one output load.
// in_stall is high while products are computed; out_stall holds the result register and
//   pauses the next output load. rst is synchronous; stores are not cleared.
`default_nettype none

module matrix_multiply_4x4 import mm4_pkg::*; #(
  parameter int DIM       = DIM_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] element,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [ROW_W-1:0]              row,
  output logic [ROW_W-1:0]              column,
  output logic signed [DATA_W-1:0]      product,
  output logic                          last
);

  localparam int CELL_W = $clog2(DIM * DIM);

  mm4_cmd_t          cmd;
  mm4_status_t       status;
  logic [CELL_W-1:0] wr_addr;
  logic [CELL_W-1:0] rd_left_addr;
  logic [CELL_W-1:0] rd_right_addr;
  logic [ROW_W-1:0]  res_row;
  logic [ROW_W-1:0]  res_column;

  mm4_ctrl #(
    .DIM    (DIM),
    .CELL_W (CELL_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .status        (status),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_left_addr  (rd_left_addr),
    .rd_right_addr (rd_right_addr),
    .res_row       (res_row),
    .res_column    (res_column)
  );

  mm4_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS),
    .CELL_W    (CELL_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_left_addr  (rd_left_addr),
    .rd_right_addr (rd_right_addr),
    .res_row       (res_row),
    .res_column    (res_column),
    .element       (element),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row           (row),
    .column        (column),
    .product       (product),
    .last          (last)
  );

endmodule

`default_nettype wire

### hdl/mm4_datapath.sv
`default_nettype none

module mm4_datapath import mm4_pkg::*; #(
  parameter int DIM       = DIM_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
  parameter int CELL_W    = $clog2(DIM * DIM)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mm4_cmd_t                 cmd,
  input  wire logic [CELL_W-1:0]        wr_addr,
  input  wire logic [CELL_W-1:0]        rd_left_addr,
  input  wire logic [CELL_W-1:0]        rd_right_addr,
  input  wire logic [ROW_W-1:0]         res_row,
  input  wire logic [ROW_W-1:0]         res_column,
  input  wire logic signed [DATA_W-1:0] element,
  output mm4_status_t                   status,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [ROW_W-1:0]              row,
  output logic [ROW_W-1:0]              column,
  output logic signed [DATA_W-1:0]      product,
  output logic                          last
);

  localparam int CELLS = DIM * DIM;
  localparam int ACC_W = 2 * DATA_W + $clog2(DIM);

  logic signed [DATA_W-1:0]   left_mem  [0:CELLS-1];
  logic signed [DATA_W-1:0]   right_mem [0:CELLS-1];
  logic signed [DATA_W-1:0]   left_q;
  logic signed [DATA_W-1:0]   right_q;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    shifted;
  logic [ACC_W-DATA_W:0]      upper;
  logic signed [DATA_W-1:0]   sat;
  logic                       rd_valid, rd_first, rd_last;
  logic                       mul_valid, mul_first, mul_last;
  logic                       acc_done;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && !cmd.wr_right) begin
      left_mem[wr_addr] <= element;
    end
    if (cmd.wr_en && cmd.wr_right) begin
      right_mem[wr_addr] <= element;
    end
    if (cmd.rd_en) begin
      left_q  <= left_mem[rd_left_addr];
      right_q <= right_mem[rd_right_addr];
    end
  end

  // read -> multiply -> accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      rd_first  <= 1'b0;
      rd_last   <= 1'b0;
      mul_valid <= 1'b0;
      mul_first <= 1'b0;
      mul_last  <= 1'b0;
      acc_done  <= 1'b0;
    end else begin
      rd_valid  <= cmd.rd_en;
      rd_first  <= cmd.first;
      rd_last   <= cmd.last_k;
      mul_valid <= rd_valid;
      mul_first <= rd_first;
      mul_last  <= rd_last;
      if (mul_valid && mul_last) begin
        acc_done <= 1'b1;
      end else if (cmd.load_out) begin
        acc_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prod <= left_q * right_q;
    end
    if (mul_valid) begin
      acc <= mul_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // arithmetic shift floors; saturate when the high bits are not all sign
  assign shifted = acc >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DATA_W-1];

  always_comb begin
    if (&upper || ~|upper) begin
      sat = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      row     <= res_row;
      column  <= res_column;
      product <= sat;
      last    <= cmd.out_last;
    end
  end

  assign status.acc_done = acc_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

### hdl/mm4_ctrl.sv
`default_nettype none

module mm4_ctrl import mm4_pkg::*; #(
  parameter int DIM    = DIM_DEFAULT,
  parameter int CELL_W = $clog2(DIM * DIM)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mm4_status_t       status,
  output mm4_cmd_t               cmd,
  output logic [CELL_W-1:0]      wr_addr,
  output logic [CELL_W-1:0]      rd_left_addr,
  output logic [CELL_W-1:0]      rd_right_addr,
  output logic [ROW_W-1:0]       res_row,
  output logic [ROW_W-1:0]       res_column
);

  localparam int CELLS = DIM * DIM;
  localparam int CNT_W = $clog2(2 * CELLS);
  localparam int IDX_W = $clog2(DIM);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_MAC  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   r, r_next;
  logic [IDX_W-1:0]   c, c_next;
  logic [IDX_W-1:0]   k, k_next;
  logic               accept;
  logic               in_left;
  logic               k_end, c_end, r_end;

  assign in_stall = (state != S_LOAD);
  assign accept   = in_valid && !in_stall;
  assign in_left  = count < CNT_W'(CELLS);
  assign k_end    = (k == IDX_W'(DIM - 1));
  assign c_end    = (c == IDX_W'(DIM - 1));
  assign r_end    = (r == IDX_W'(DIM - 1));

  assign wr_addr       = in_left ? CELL_W'(count) : CELL_W'(count - CNT_W'(CELLS));
  assign rd_left_addr  = CELL_W'(r) * CELL_W'(DIM) + CELL_W'(k);
  assign rd_right_addr = CELL_W'(k) * CELL_W'(DIM) + CELL_W'(c);
  assign res_row       = ROW_W'(r);
  assign res_column    = ROW_W'(c);

  always_comb begin
    state_next = state;
    count_next = count;
    r_next     = r;
    c_next     = c;
    k_next     = k;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        cmd.wr_en    = accept;
        cmd.wr_right = !in_left;
        if (accept) begin
          if (count == CNT_W'(2 * CELLS - 1)) begin
            count_next = '0;
            r_next     = '0;
            c_next     = '0;
            k_next     = '0;
            state_next = S_MAC;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      S_MAC: begin
        cmd.rd_en  = 1'b1;
        cmd.first  = (k == '0);
        cmd.last_k = k_end;
        if (k_end) begin
          k_next     = '0;
          state_next = S_WAIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_WAIT: begin
        if (status.acc_done && status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = r_end && c_end;
          if (c_end) begin
            c_next = '0;
            r_next = r + 1'b1;
          end else begin
            c_next = c + 1'b1;
          end
          state_next = (r_end && c_end) ? S_LOAD : S_MAC;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
    end
  end

endmodule

`default_nettype wire

### hdl/mm4_checker.sv
`default_nettype none
`include "matrix_multiply_4x4_defines.svh"

module mm4_checker import mm4_pkg::*; #(
  parameter int DIM = DIM_DEFAULT
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [ROW_W-1:0]         row,
  input wire logic [ROW_W-1:0]         column,
  input wire logic signed [DATA_W-1:0] product,
  input wire logic                     last
);

  // no new elements are taken while a run still has results to show
  `MM4_ASSERT_NOW(a_no_load_mid_run, out_valid && !last, in_stall, "input taken mid run")

  `MM4_ASSERT_NOW(a_last_corner, out_valid && last,
    (row == ROW_W'(DIM - 1)) && (column == ROW_W'(DIM - 1)), "last flag off the final cell")

  // a new run needs a full load before any result
  `MM4_ASSERT_NEXT(a_idle_after_last, out_valid && !out_stall && last, !out_valid,
    "result right after last transfer")

  `MM4_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(product) && $stable(row) && $stable(column) && $stable(last),
    "stalled result changed")

endmodule

bind matrix_multiply_4x4 mm4_checker #(.DIM(DIM)) u_mm4_checker (.*);

`default_nettype wire

### tb/sv/matrix_multiply_4x4_test.sv
`timescale 1ns / 1ps

module matrix_multiply_4x4_test;
  import mm4_pkg::*;

  localparam int DIM   = DIM_DEFAULT;
  localparam int FRAC  = FRAC_BITS_DEFAULT;
  localparam int CELLS = DIM * DIM;
  localparam int RANDOM_PAIRS = 14;
  localparam int MAX_PRINTED  = 40;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef enum int {MIX_SMALL, MIX_WIDE, MIX_EDGE} element_mix_t;

  typedef struct {
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         column;
    logic signed [DATA_W-1:0] product;
    logic                     last;
  } product_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] element = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ROW_W-1:0]         row;
  logic [ROW_W-1:0]         column;
  logic signed [DATA_W-1:0] product;
  logic                     last;

  // Mirrors the two operand stores and queues the 16 products of each loaded pair.
  class matmul_tracker_t;
    logic signed [DATA_W-1:0] left_m[CELLS];
    logic signed [DATA_W-1:0] right_m[CELLS];
    int       loaded;
    product_t pending[$];
    int       mismatches;
    int       checked;

    function new();
      loaded = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("mismatch: %s", msg);
    endtask

    // Full-width dot product, arithmetic shift (rounds toward minus infinity), saturate.
    function logic signed [DATA_W-1:0] fixed_dot(int r, int c);
      logic signed [127:0] acc;
      logic signed [63:0]  term;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        term = 64'(left_m[r*DIM + k]) * 64'(right_m[k*DIM + c]);
        acc = acc + 128'(term);
      end
      acc = acc >>> FRAC;
      if (acc > 128'sd2147483647)
        return Q_MAX;
      if (acc < -128'sd2147483648)
        return Q_MIN;
      return acc[DATA_W-1:0];
    endfunction

    function void load_element(logic signed [DATA_W-1:0] v);
      product_t p;
      if (loaded < CELLS)
        left_m[loaded] = v;
      else
        right_m[loaded - CELLS] = v;
      loaded++;
      if (loaded < 2 * CELLS)
        return;
      loaded = 0;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          p.row     = ROW_W'(r);
          p.column  = ROW_W'(c);
          p.product = fixed_dot(r, c);
          p.last    = (r == DIM - 1) && (c == DIM - 1);
          pending.push_back(p);
        end
      end
    endfunction

    task check_product(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c,
                       logic signed [DATA_W-1:0] p, logic l);
      product_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected product row %0d col %0d value %0d",
                                  r, c, p));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (r !== want.row)
        report_mismatch($sformatf("row %0d, expected %0d", r, want.row));
      if (c !== want.column)
        report_mismatch($sformatf("column %0d, expected %0d", c, want.column));
      if (p !== want.product)
        report_mismatch($sformatf("product at (%0d,%0d) is %0d, expected %0d",
                                  want.row, want.column, p, want.product));
      if (l !== want.last)
        report_mismatch($sformatf("last flag %b at (%0d,%0d), expected %b",
                                  l, want.row, want.column, want.last));
    endtask
  endclass

  matmul_tracker_t tracker = new();

  matrix_multiply_4x4 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .element   (element),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row       (row),
    .column    (column),
    .product   (product),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_element(input logic signed [DATA_W-1:0] v, input bit idle_on);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    element  <= v;
    do @(posedge clk); while (in_stall);
    tracker.load_element(v);
    @(negedge clk);
  endtask

  initial begin : drain
    int  hold;
    int  run_left;
    bit  hold_on;
    run_left = 0;
    hold_on = 1'b1;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      // hold pattern is redrawn per run of results so some runs see no stalls
      if (run_left == 0) begin
        hold_on = ($urandom_range(0, 3) != 0);
        run_left = CELLS;
      end
      run_left--;
      hold = hold_on ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.check_product(row, column, product, last);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic signed [DATA_W-1:0] a_tail[DIM];
    logic signed [DATA_W-1:0] b_col2[DIM];
    logic signed [DATA_W-1:0] v;
    element_mix_t mix;
    bit           idle_on;
    int           r;
    int           c;
    int           pairs;

    a_tail = '{32'shFFFF_FFFF, 32'sd1, 32'sh0001_8000, 32'shFFFF_0000};
    b_col2 = '{32'sd1, 32'shFFFF_8000, 32'sh0003_0000, 32'shFFFF_FFFF};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pair: saturation both ways, a sum past 64 bits, exact shifts and
    // inexact positive sums that round toward minus infinity.
    for (int i = 0; i < 2 * CELLS; i++) begin
      r = (i % CELLS) / DIM;
      c = i % DIM;
      if (i < CELLS) begin
        case (r)
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = (c == 2) ? Q_ONE : '0;
          default: v = a_tail[c];
        endcase
      end else begin
        case (c)
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = b_col2[r];
          default: v = '0;
        endcase
      end
      send_element(v, 1'b1);
    end
    pairs = 1;

    for (int p = 0; p < RANDOM_PAIRS; p++) begin
      mix = element_mix_t'($urandom_range(0, 2));
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 2 * CELLS; i++) begin
        case (mix)
          MIX_SMALL: v = $signed($urandom_range(0, 32'hF_FFFF)) - 32'sd524288;
          MIX_WIDE:  v = $urandom();
          default: begin
            case ($urandom_range(0, 5))
              0: v = Q_MAX;
              1: v = Q_MIN;
              2: v = '0;
              3: v = Q_ONE;
              4: v = -Q_ONE;
              default: v = $urandom();
            endcase
          end
        endcase
        send_element(v, idle_on);
      end
      pairs++;
    end
    in_valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run: %0d matrix pairs (%0d element transfers), %0d products checked",
             pairs, pairs * 2 * CELLS, tracker.checked);
    $display("run: %0d mismatches", tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
